@@ rtl/core/lcwf_pkg.sv @@
// ----------------------------------------------------------------------------
// lcwf_pkg - shared types and constants for the load-cell window filter
// Item layouts, widths, opcode bits, register indexes and the command and
// status bundles that join the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package lcwf_pkg;

    localparam int MAX_SAMPLES = 64;
    localparam int FRAC_BITS   = 8;

    localparam int SAMPLE_W  = 24;
    localparam int REF_W     = 32;
    localparam int OUT_W     = 34;
    localparam int STATUS_W  = 2;
    localparam int OP_W      = 2;
    localparam int CFG_IDX_W = 1;

    localparam int ADDR_W    = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
    localparam int CNT_W     = $clog2(MAX_SAMPLES + 1);
    localparam int SUM_W     = SAMPLE_W + CNT_W;
    localparam int NUM_W     = SUM_W + 1;
    localparam int DIVN_W    = NUM_W + FRAC_BITS;
    localparam int DEN_W     = CNT_W + REF_W + 1;
    localparam int MAG_W     = DIVN_W + FRAC_BITS;
    localparam int DIV_CNT_W = $clog2(DIVN_W + 1);

    // opcode bits
    localparam int OP_MEAN_BIT = 0;
    localparam int OP_TARE_BIT = 1;

    // status bits
    localparam int ST_DROPPED_BIT  = 0;
    localparam int ST_ZERO_REF_BIT = 1;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_REF_UNIT      = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_PRESET = 1'd1;

    // saturation limits, as magnitudes
    localparam logic [MAG_W-1:0] NEG_LIM = MAG_W'(1) << (OUT_W - 1);
    localparam logic [MAG_W-1:0] POS_LIM = NEG_LIM - MAG_W'(1);

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       last_sample;
        logic [OP_W-1:0]            opcode;
    } in_item_t;

    typedef struct packed {
        logic signed [OUT_W-1:0] scaled_value;
        logic [STATUS_W-1:0]     status;
    } out_item_t;

    typedef struct packed {
        logic              in_acc;
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic [ADDR_W-1:0] rd_addr;
        logic              start;
        logic              sum_en;
        logic              cnt_clr;
        logic              cand_ld;
        logic              cmp_en;
        logic              rank_chk;
        logic              prep1;
        logic              prep2;
        logic              div_step;
        logic              fin;
        logic [CNT_W-1:0]  n;
        logic              dropped;
    } ctl_cmd_t;

    typedef struct packed {
        logic mean;
        logic out_free;
    } dp_stat_t;

endpackage

`default_nettype wire

@@ rtl/core/lcwf_ctrl.sv @@
// ----------------------------------------------------------------------------
// lcwf_ctrl - sequencer for the load-cell window filter
// Counts the run, walks the sample store for the sum or the rank search,
// and steps the divider.
// ----------------------------------------------------------------------------
`default_nettype none

module lcwf_ctrl
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire logic              last_sample,
    input  wire lcwf_pkg::dp_stat_t stat,
    output lcwf_pkg::ctl_cmd_t     cmd
);
    import lcwf_pkg::*;

    localparam logic [3:0] S_LOAD   = 4'd0;
    localparam logic [3:0] S_START  = 4'd1;
    localparam logic [3:0] S_SUM    = 4'd2;
    localparam logic [3:0] S_SDRAIN = 4'd3;
    localparam logic [3:0] S_CRD    = 4'd4;
    localparam logic [3:0] S_CLD    = 4'd5;
    localparam logic [3:0] S_CSCAN  = 4'd6;
    localparam logic [3:0] S_CDRAIN = 4'd7;
    localparam logic [3:0] S_CCHK   = 4'd8;
    localparam logic [3:0] S_PREP1  = 4'd9;
    localparam logic [3:0] S_PREP2  = 4'd10;
    localparam logic [3:0] S_DIV    = 4'd11;
    localparam logic [3:0] S_FIN    = 4'd12;

    logic [3:0]           state_reg, state_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic                 dropped_reg, dropped_next;
    logic [CNT_W-1:0]     idx_reg, idx_next;
    logic [CNT_W-1:0]     cidx_reg, cidx_next;
    logic                 pend_reg, pend_next;
    logic [DIV_CNT_W-1:0] div_cnt_reg, div_cnt_next;
    logic                 accept;
    logic [CNT_W-1:0]     last_idx;

    assign in_stall = (state_reg != S_LOAD);
    assign accept   = in_valid && !in_stall;
    assign last_idx = cnt_reg - CNT_W'(1);

    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        dropped_next = dropped_reg;
        idx_next     = idx_reg;
        cidx_next    = cidx_reg;
        pend_next    = 1'b0;
        div_cnt_next = div_cnt_reg;
        cmd          = '0;
        cmd.n        = cnt_reg;
        cmd.dropped  = dropped_reg;
        cmd.wr_addr  = cnt_reg[ADDR_W-1:0];
        cmd.rd_addr  = idx_reg[ADDR_W-1:0];
        unique case (state_reg)
            S_LOAD:
            begin
                if (accept)
                begin
                    cmd.in_acc = 1'b1;
                    if (cnt_reg < CNT_W'(MAX_SAMPLES))
                    begin
                        cmd.wr_en = 1'b1;
                        cnt_next  = cnt_reg + CNT_W'(1);
                    end
                    else
                    begin
                        dropped_next = 1'b1;
                    end
                    if (last_sample)
                    begin
                        state_next = S_START;
                    end
                end
            end
            S_START:
            begin
                cmd.start  = 1'b1;
                idx_next   = '0;
                cidx_next  = '0;
                state_next = stat.mean ? S_SUM : S_CRD;
            end
            S_SUM:
            begin
                cmd.sum_en = pend_reg;
                pend_next  = 1'b1;
                idx_next   = idx_reg + CNT_W'(1);
                if (idx_reg == last_idx)
                begin
                    state_next = S_SDRAIN;
                end
            end
            S_SDRAIN:
            begin
                cmd.sum_en = pend_reg;
                state_next = S_PREP1;
            end
            S_CRD:
            begin
                cmd.rd_addr = cidx_reg[ADDR_W-1:0];
                cmd.cnt_clr = 1'b1;
                idx_next    = '0;
                state_next  = S_CLD;
            end
            S_CLD:
            begin
                cmd.cand_ld = 1'b1;
                pend_next   = 1'b1;
                idx_next    = idx_reg + CNT_W'(1);
                state_next  = (idx_reg == last_idx) ? S_CDRAIN : S_CSCAN;
            end
            S_CSCAN:
            begin
                cmd.cmp_en = pend_reg;
                pend_next  = 1'b1;
                idx_next   = idx_reg + CNT_W'(1);
                if (idx_reg == last_idx)
                begin
                    state_next = S_CDRAIN;
                end
            end
            S_CDRAIN:
            begin
                cmd.cmp_en = pend_reg;
                state_next = S_CCHK;
            end
            S_CCHK:
            begin
                cmd.rank_chk = 1'b1;
                cidx_next    = cidx_reg + CNT_W'(1);
                state_next   = (cidx_reg == last_idx) ? S_PREP1 : S_CRD;
            end
            S_PREP1:
            begin
                cmd.prep1  = 1'b1;
                state_next = S_PREP2;
            end
            S_PREP2:
            begin
                cmd.prep2    = 1'b1;
                div_cnt_next = '0;
                state_next   = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                div_cnt_next = div_cnt_reg + DIV_CNT_W'(1);
                if (div_cnt_reg == DIV_CNT_W'(DIVN_W - 1))
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (stat.out_free)
                begin
                    cmd.fin      = 1'b1;
                    cnt_next     = '0;
                    dropped_next = 1'b0;
                    state_next   = S_LOAD;
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_LOAD;
            cnt_reg     <= '0;
            dropped_reg <= 1'b0;
            idx_reg     <= '0;
            cidx_reg    <= '0;
            pend_reg    <= 1'b0;
            div_cnt_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            dropped_reg <= dropped_next;
            idx_reg     <= idx_next;
            cidx_reg    <= cidx_next;
            pend_reg    <= pend_next;
            div_cnt_reg <= div_cnt_next;
        end
    end

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(MAX_SAMPLES))
        else $error("sample count beyond store depth");

    a_run_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FIN && stat.out_free) |=> (cnt_reg == '0 && !dropped_reg))
        else $error("run state not cleared after result");

    a_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_START) |-> (cnt_reg != '0))
        else $error("reduction started on an empty run");
`endif

endmodule

`default_nettype wire

@@ rtl/core/lcwf_dp.sv @@
// ----------------------------------------------------------------------------
// lcwf_dp - datapath for the load-cell window filter
// Sample store, sum and rank counters, restoring divider, output register
// and the configuration registers.
// ----------------------------------------------------------------------------
`default_nettype none

module lcwf_dp
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire lcwf_pkg::ctl_cmd_t            cmd,
    output lcwf_pkg::dp_stat_t                 stat,
    input  wire lcwf_pkg::in_item_t            in_data,
    input  wire logic                          cfg_valid,
    input  wire logic [lcwf_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [lcwf_pkg::REF_W-1:0]    cfg_data,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output lcwf_pkg::out_item_t                out_data
);
    import lcwf_pkg::*;

    logic signed [SAMPLE_W-1:0] mem [MAX_SAMPLES];
    logic signed [SAMPLE_W-1:0] rd_data_reg;
    logic [OP_W-1:0]            op_reg;
    logic signed [REF_W-1:0]    ref_reg;
    logic signed [SAMPLE_W-1:0] off_reg;
    logic signed [SUM_W-1:0]    sum_reg;
    logic signed [SAMPLE_W-1:0] cand_reg, va_reg, vb_reg;
    logic [CNT_W-1:0]           lt_reg, le_reg;
    logic signed [NUM_W-1:0]    p_reg, prod_reg;
    logic [CNT_W-1:0]           d_reg;
    logic [DEN_W-1:0]           den_reg;
    logic                       neg_reg;
    logic [DEN_W-1:0]           rem_reg;
    logic [DIVN_W-1:0]          quo_reg;
    logic                       out_valid_reg;
    out_item_t                  out_data_reg;

    logic                       is_mean, is_tare;
    logic [CNT_W-1:0]           half, ka, kb, d_sel;
    logic signed [NUM_W-1:0]    p_sel, off_ext, d_ext, num;
    logic [REF_W-1:0]           ref_mag;
    logic [NUM_W-1:0]           num_mag, p_mag;
    logic [DEN_W:0]             rem_sh;
    logic                       ge;
    logic [MAG_W-1:0]           mag;
    logic signed [OUT_W-1:0]    res;
    logic [DIVN_W-1:0]          r_full;
    logic [STATUS_W-1:0]        status;

    assign is_mean = op_reg[OP_MEAN_BIT];
    assign is_tare = op_reg[OP_TARE_BIT];

    assign stat.mean     = is_mean;
    assign stat.out_free = !out_valid_reg || !out_stall;
    assign out_valid     = out_valid_reg;
    assign out_data      = out_data_reg;

    // median ranks: the two middle ranks, equal for an odd count
    assign half = cmd.n >> 1;
    assign kb   = half;
    assign ka   = cmd.n[0] ? half : half - CNT_W'(1);

    assign d_sel   = is_mean ? cmd.n : CNT_W'(2);
    assign p_sel   = is_mean ? NUM_W'(sum_reg) : (NUM_W'(va_reg) + NUM_W'(vb_reg));
    assign off_ext = NUM_W'(off_reg);
    assign d_ext   = $signed(NUM_W'(d_sel));
    assign ref_mag = ref_reg[REF_W-1] ? (~ref_reg + REF_W'(1)) : ref_reg;

    assign num     = p_reg - prod_reg;
    assign num_mag = num[NUM_W-1] ? (~num + NUM_W'(1)) : num;
    assign p_mag   = p_reg[NUM_W-1] ? (~p_reg + NUM_W'(1)) : p_reg;

    assign rem_sh = {rem_reg, quo_reg[DIVN_W-1]};
    assign ge     = rem_sh >= {1'b0, den_reg};

    always_comb
    begin
        mag = is_tare ? (MAG_W'(quo_reg) << FRAC_BITS) : MAG_W'(quo_reg);
        if (neg_reg)
        begin
            res = (mag >= NEG_LIM) ? NEG_LIM[OUT_W-1:0] : (~mag[OUT_W-1:0] + OUT_W'(1));
        end
        else
        begin
            res = (mag > POS_LIM) ? POS_LIM[OUT_W-1:0] : mag[OUT_W-1:0];
        end
        status                  = '0;
        status[ST_DROPPED_BIT]  = cmd.dropped;
        if (!is_tare && ref_reg == '0)
        begin
            res                     = '0;
            status[ST_ZERO_REF_BIT] = 1'b1;
        end
        r_full = neg_reg ? (~quo_reg + DIVN_W'(1)) : quo_reg;
    end

    // sample store
    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            mem[cmd.wr_addr] <= in_data.sample;
        end
        rd_data_reg <= mem[cmd.rd_addr];
    end

    // reduction and divider datapath
    always_ff @(posedge clk)
    begin
        if (cmd.in_acc)
        begin
            op_reg <= in_data.opcode;
        end
        if (cmd.start)
        begin
            sum_reg <= '0;
        end
        if (cmd.sum_en)
        begin
            sum_reg <= sum_reg + SUM_W'(rd_data_reg);
        end
        if (cmd.cnt_clr)
        begin
            lt_reg <= '0;
            le_reg <= '0;
        end
        if (cmd.cand_ld)
        begin
            cand_reg <= rd_data_reg;
        end
        if (cmd.cmp_en)
        begin
            lt_reg <= lt_reg + CNT_W'(rd_data_reg < cand_reg);
            le_reg <= le_reg + CNT_W'(rd_data_reg <= cand_reg);
        end
        if (cmd.rank_chk)
        begin
            if (lt_reg <= ka && ka < le_reg)
            begin
                va_reg <= cand_reg;
            end
            if (lt_reg <= kb && kb < le_reg)
            begin
                vb_reg <= cand_reg;
            end
        end
        if (cmd.prep1)
        begin
            p_reg    <= p_sel;
            d_reg    <= d_sel;
            prod_reg <= off_ext * d_ext;
            den_reg  <= is_tare ? (DEN_W'(d_sel) << 1) : (DEN_W'(d_sel) * DEN_W'(ref_mag));
        end
        if (cmd.prep2)
        begin
            rem_reg <= '0;
            if (is_tare)
            begin
                // round half away from zero: (2|p| + d) / 2d
                quo_reg <= DIVN_W'({p_mag, 1'b0}) + DIVN_W'(d_reg);
                neg_reg <= p_reg[NUM_W-1];
            end
            else
            begin
                quo_reg <= DIVN_W'(num_mag) << FRAC_BITS;
                neg_reg <= num[NUM_W-1] ^ ref_reg[REF_W-1];
            end
        end
        if (cmd.div_step)
        begin
            rem_reg <= ge ? DEN_W'(rem_sh - {1'b0, den_reg}) : rem_sh[DEN_W-1:0];
            quo_reg <= {quo_reg[DIVN_W-2:0], ge};
        end
        if (cmd.fin)
        begin
            out_data_reg.scaled_value <= res;
            out_data_reg.status       <= status;
        end
    end

    // configuration registers and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ref_reg       <= REF_W'(1);
            off_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    CFG_REF_UNIT:      ref_reg <= cfg_data;
                    CFG_OFFSET_PRESET: off_reg <= cfg_data[SAMPLE_W-1:0];
                    default:           ref_reg <= ref_reg;
                endcase
            end
            if (cmd.fin && is_tare)
            begin
                off_reg <= r_full[SAMPLE_W-1:0];
            end
            if (cmd.fin)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/load_cell_window_filter_scale_top.sv @@
// Mean run: one pass over the sample store forms the sum, then a restoring
// divider runs. Median run: each candidate sample is ranked by one pass
// over the sample store, then the restoring divider runs.
// Throughput: one sample per cycle while loading; a new run loads while the
// previous result waits in the output register.
// Reset: asynchronous, active low; clears count, flags, offset, ref unit to 1.
// ----------------------------------------------------------------------------
// load_cell_window_filter_scale_top - median or mean window filter with tare
// Buffers a run of load-cell samples, reduces it to its median or mean, and
// either scales it against the stored offset or stores it as a new offset.
// ----------------------------------------------------------------------------
`default_nettype none

module load_cell_window_filter_scale_top
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // sample items
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire lcwf_pkg::in_item_t            in_data,
    // result items
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output lcwf_pkg::out_item_t                out_data,
    // register writes
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [lcwf_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [lcwf_pkg::REF_W-1:0]    cfg_data
);
    import lcwf_pkg::*;

    ctl_cmd_t cmd;
    dp_stat_t stat;

    // registers are to be written only while idle (the user's duty, not enforced here), so always take a write
    assign cfg_ready = 1'b1;

    // controller: hold input stalled from the last item until the result
    // is handed to the output register
    lcwf_ctrl u_ctrl
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .last_sample (in_data.last_sample),
        .stat        (stat),
        .cmd         (cmd)
    );

    // datapath: store, rank search, divider and output register
    lcwf_dp u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .in_data   (in_data),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

`default_nettype wire
